[rtl/media_playhead_timer_assert.svh]
// Assertion helpers for the playhead timer
`ifndef MEDIA_PLAYHEAD_TIMER_ASSERT_SVH
`define MEDIA_PLAYHEAD_TIMER_ASSERT_SVH
`ifndef SYNTH
`define MPT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("playhead timer check failed");
`define MPT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("playhead timer check failed");
`else
`define MPT_ASSERT(lbl, clk, rstn, prop)
`define MPT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/mpt_pkg.sv]
package mpt_pkg;

  localparam int TIME_W  = 40;
  localparam int FRAME_W = 31;
  localparam int FPS_W   = 10;
  localparam int FD_W    = 20;
  localparam int DVD_W   = 52;
  localparam int SEEK_W  = 48;
  localparam int IDX_W   = 32;
  localparam int DLT_W   = 32;
  localparam int CNT_W   = $clog2(DVD_W + 1);

  localparam logic [FD_W-1:0]    US_PER_SEC = 20'd1000000;
  localparam logic [FPS_W-1:0]   FPS_RESET  = 10'd30;
  localparam logic [FRAME_W-1:0] FRAME_MAX  = {FRAME_W{1'b1}};

  typedef enum logic [2:0] {
    CMD_PLAY, CMD_PAUSE, CMD_TOGGLE, CMD_SEEK_TIME, CMD_SEEK_FRAME, CMD_ADVANCE, CMD_QUERY
  } cmd_e;

  typedef enum logic [1:0] {REG_FPS, REG_DUR, REG_LOOP} reg_e;

  typedef enum logic [1:0] {DIV_SEEK, DIV_WRAP, DIV_FD, DIV_FRAME} div_sel_e;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SEEK, S_SEEK_W, S_WRAP, S_WRAP_W, S_FD, S_FD_W, S_FRM, S_FRM_W, S_OUT
  } state_e;

  typedef struct packed {
    logic     load;
    logic     exec;
    logic     div_start;
    logic     div_store;
    div_sel_e div_sel;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic seek_frame;
    logic need_wrap;
    logic div_done;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/mpt_div.sv]
module mpt_div
  import mpt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [TIME_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DVD_W-1:0]  quot_o,
  output logic [TIME_W-1:0] rem_o
);

  logic [DVD_W-1:0]  dvd_q;
  logic [TIME_W-1:0] dsr_q, rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [TIME_W:0]   rem_sh, rem_nx;
  logic              ge;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    rem_nx = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  // shift quotient bits in where dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= rem_nx[TIME_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

[rtl/mpt_datapath.sv]
module mpt_datapath
  import mpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_stat_t    stat_o,
  input  logic [2:0]  s_user_i,
  input  logic [111:0] s_data_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  output logic [63:0] cfg_rdata_o,
  input  logic        m_ready_i,
  output logic        m_valid_o,
  output logic [71:0] m_data_o
);

  // configuration and state
  logic [FPS_W-1:0]  fps_q;
  logic [TIME_W-1:0] dur_q, ph_q;
  logic              loop_q, playing_q;
  // latched word
  cmd_e              cmd_q;
  logic [SEEK_W-1:0] st_q;
  logic [IDX_W-1:0]  fi_q;
  logic [DLT_W-1:0]  dlt_q;
  // intermediates
  logic [DVD_W-1:0]  prod_q;
  logic [TIME_W:0]   next_q;
  logic [FD_W-1:0]   fd_q;
  logic [FRAME_W-1:0] frame_q;
  // output register
  logic              m_valid_q;
  logic [71:0]       m_data_q;

  logic [TIME_W:0]   sum;
  logic              at_end;
  logic [TIME_W-1:0] st_clamped;
  logic [DVD_W-1:0]  div_dvd;
  logic [TIME_W-1:0] div_dsr;
  logic              div_busy, div_done;
  logic [DVD_W-1:0]  div_quot;
  logic [TIME_W-1:0] div_rem;
  reg_e              reg_idx;

  assign reg_idx = reg_e'(cfg_addr_i[4:3]);

  always_comb begin
    sum    = {1'b0, ph_q} + {{(TIME_W + 1 - DLT_W){1'b0}}, dlt_q};
    at_end = sum >= {1'b0, dur_q};
    if (st_q[SEEK_W-1])
      st_clamped = '0;
    else if (st_q[SEEK_W-2:0] > {{(SEEK_W - 1 - TIME_W){1'b0}}, dur_q})
      st_clamped = dur_q;
    else
      st_clamped = st_q[TIME_W-1:0];
  end

  // divider operand selection
  always_comb begin
    case (cmd_i.div_sel)
      DIV_SEEK: begin
        div_dvd = prod_q;
        div_dsr = {{(TIME_W - FPS_W){1'b0}}, fps_q};
      end
      DIV_WRAP: begin
        div_dvd = {{(DVD_W - TIME_W - 1){1'b0}}, next_q};
        div_dsr = dur_q;
      end
      DIV_FD: begin
        div_dvd = {{(DVD_W - FD_W){1'b0}}, US_PER_SEC};
        div_dsr = {{(TIME_W - FPS_W){1'b0}}, fps_q};
      end
      default: begin
        div_dvd = {{(DVD_W - TIME_W){1'b0}}, ph_q}
                + {{(DVD_W - FD_W + 1){1'b0}}, fd_q[FD_W-1:1]};
        div_dsr = {{(TIME_W - FD_W){1'b0}}, fd_q};
      end
    endcase
  end

  mpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // latch the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= cmd_e'(s_user_i);
      st_q  <= s_data_i[47:0];
      fi_q  <= s_data_i[79:48];
      dlt_q <= s_data_i[111:80];
    end
  end

  // configuration, playhead and playing flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q     <= FPS_RESET;
      dur_q     <= '0;
      loop_q    <= 1'b0;
      ph_q      <= '0;
      playing_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx)
          REG_FPS:  if (cfg_wdata_i[FPS_W-1:0] != '0) fps_q <= cfg_wdata_i[FPS_W-1:0];
          REG_DUR: begin
            dur_q <= cfg_wdata_i[TIME_W-1:0];
            if (ph_q > cfg_wdata_i[TIME_W-1:0]) ph_q <= cfg_wdata_i[TIME_W-1:0];
          end
          REG_LOOP: loop_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        case (cmd_q)
          CMD_PLAY:      playing_q <= 1'b1;
          CMD_PAUSE:     playing_q <= 1'b0;
          CMD_TOGGLE:    playing_q <= !playing_q;
          CMD_SEEK_TIME: ph_q <= st_clamped;
          CMD_ADVANCE: begin
            if (playing_q) begin
              if (!at_end) begin
                ph_q <= sum[TIME_W-1:0];
              end else if (!(loop_q && dur_q != '0)) begin
                ph_q      <= dur_q;
                playing_q <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.div_store) begin
        case (cmd_i.div_sel)
          DIV_SEEK:
            ph_q <= (div_quot > {{(DVD_W - TIME_W){1'b0}}, dur_q}) ? dur_q
                                                                  : div_quot[TIME_W-1:0];
          DIV_WRAP: ph_q <= div_rem;
          default: ;
        endcase
      end
    end
  end

  // product for a frame seek, sum for a wrap, frame period, frame number
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      prod_q <= fi_q[IDX_W-1] ? '0
              : DVD_W'({fi_q[IDX_W-2:0]} * US_PER_SEC);
      next_q <= sum;
    end
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        DIV_FD:    fd_q <= div_quot[FD_W-1:0];
        DIV_FRAME: frame_q <= (div_quot > {{(DVD_W - FRAME_W){1'b0}}, FRAME_MAX}) ? FRAME_MAX
                                                                   : div_quot[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) m_data_q <= {playing_q, frame_q, ph_q};
  end

  // register read-back
  always_comb begin
    case (reg_idx)
      REG_FPS:  cfg_rdata_o = {{(64 - FPS_W){1'b0}}, fps_q};
      REG_DUR:  cfg_rdata_o = {{(64 - TIME_W){1'b0}}, dur_q};
      REG_LOOP: cfg_rdata_o = {63'd0, loop_q};
      default:  cfg_rdata_o = '0;
    endcase
  end

  assign stat_o.seek_frame = (cmd_q == CMD_SEEK_FRAME);
  assign stat_o.need_wrap  = (cmd_q == CMD_ADVANCE) && playing_q && at_end && loop_q
                             && (dur_q != '0);
  assign stat_o.div_done   = div_done;
  assign stat_o.div_busy   = div_busy;
  assign stat_o.out_free   = !m_valid_q || m_ready_i;
  assign m_valid_o         = m_valid_q;
  assign m_data_o          = m_data_q;

endmodule

[rtl/mpt_ctrl.sv]
module mpt_ctrl
  import mpt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // walk the command through its divisions
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = DIV_FRAME;
    s_ready_o     = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        cmd_o.load = s_valid_i;
        if (s_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.seek_frame)     state_d = S_SEEK;
        else if (stat_i.need_wrap) state_d = S_WRAP;
        else                       state_d = S_FD;
      end
      S_SEEK: begin
        cmd_o.div_sel = DIV_SEEK; cmd_o.div_start = 1'b1; state_d = S_SEEK_W;
      end
      S_SEEK_W: begin
        cmd_o.div_sel = DIV_SEEK; cmd_o.div_store = stat_i.div_done;
        if (stat_i.div_done) state_d = S_FD;
      end
      S_WRAP: begin
        cmd_o.div_sel = DIV_WRAP; cmd_o.div_start = 1'b1; state_d = S_WRAP_W;
      end
      S_WRAP_W: begin
        cmd_o.div_sel = DIV_WRAP; cmd_o.div_store = stat_i.div_done;
        if (stat_i.div_done) state_d = S_FD;
      end
      S_FD: begin
        cmd_o.div_sel = DIV_FD; cmd_o.div_start = 1'b1; state_d = S_FD_W;
      end
      S_FD_W: begin
        cmd_o.div_sel = DIV_FD; cmd_o.div_store = stat_i.div_done;
        if (stat_i.div_done) state_d = S_FRM;
      end
      S_FRM: begin
        cmd_o.div_start = 1'b1; state_d = S_FRM_W;
      end
      S_FRM_W: begin
        cmd_o.div_store = stat_i.div_done;
        if (stat_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        cmd_o.out_load = stat_i.out_free;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[rtl/media_playhead_timer.sv]
// Channel  Dir  Handshake               Contents
// s_axis   in   tvalid/tready           command word (kind in tuser)
// m_axis   out  tvalid/tready           time, frame number, playing flag
// apb      in   psel/penable/pwrite     frame rate, duration, loop enable
//
// One command at a time; a frame seek or a wrap needs one division more than other commands.
// Every division runs on the shared 52-step restoring divider.
// Reset puts the playhead at 0, paused, 30 fps, zero duration, no loop.
// A result waits in the output register; a stalled master side holds the
// command in its final cycle until the register frees, and no new word enters.
`include "media_playhead_timer_assert.svh"
module media_playhead_timer
  import mpt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // seek_time_us[47:0], frame_index, delta_us
  input  logic [2:0]   s_axis_tuser,  // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,  // time_us[39:0], frame_number[70:40], is_playing
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign pready = 1'b1;

  mpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  mpt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_user_i    (s_axis_tuser),
    .s_data_i    (s_axis_tdata),
    .cfg_we_i    (psel && penable && pwrite && pready),
    .cfg_addr_i  (paddr),
    .cfg_wdata_i (pwdata),
    .cfg_rdata_o (prdata),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata)
  );

  `MPT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `MPT_ASSERT(a_idle_div_free, clk_i, rst_ni, s_axis_tready |-> !stat.div_busy)

endmodule
